// ===== design/smsk_pkg.sv =====
// ---------------------------------------------------------------------------
// smsk_pkg - shared types and constants of the 3x3 sharpening mask stream
// Line store geometry, queue sizing, register map and the structs passed
// between the front end, the task queue and the back end.
// ---------------------------------------------------------------------------
package smsk_pkg;

   // line stores: one entry per sample position in a row
   localparam int STORE_DEPTH = 8192;
   localparam int STORE_AW    = 13;

   // old centre samples kept for the left neighbour
   localparam int WIN_DEPTH = 12;
   localparam int WIN_IW    = 4;

   // counters
   localparam int COL_W = 13;
   localparam int ROW_W = 11;

   // task queue between front and back end
   localparam int QDEPTH = 4;
   localparam int QAW    = 2;
   localparam int QCW    = 3;

   // configuration register indexes
   localparam logic [1:0] REG_WIDTH_PIXELS  = 2'd0;
   localparam logic [1:0] REG_HEIGHT_ROWS   = 2'd1;
   localparam logic [1:0] REG_CHANNEL_COUNT = 2'd2;

   // configuration reset values
   localparam logic [11:0] WIDTH_RESET   = 12'd640;
   localparam logic [11:0] HEIGHT_RESET  = 12'd480;
   localparam logic [2:0]  CHANNEL_RESET = 3'd3;

   // height clamp limits
   localparam logic [11:0] HEIGHT_MIN = 12'd3;
   localparam logic [11:0] HEIGHT_MAX = 12'd2048;

   // mask gain on the centre sample is 5: centre*4 + centre

   typedef struct packed {
      logic [11:0] width_pixels;
      logic [11:0] height_rows;
      logic [2:0]  channel_count;
   } cfg_type;

   // one classified item ready for the arithmetic
   typedef struct packed {
      logic [7:0] centre;
      logic [7:0] upper;
      logic [7:0] left;
      logic [7:0] right;
      logic [7:0] below;
      logic       border;
      logic       row_end;
      logic       frame_end;
   } task_type;

endpackage

// ===== design/smsk_front.sv =====
// ---------------------------------------------------------------------------
// smsk_front - sample intake, line stores and classification
// Accepts samples, tracks column and row, reads the neighbourhood from the
// two line stores and the window, and pushes one task per emitted result.
// ---------------------------------------------------------------------------
module smsk_front #(
   parameter int MAX_WIDTH    = 2048,
   parameter int MAX_CHANNELS = 4
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  logic [7:0]                 req_sample,
   input  smsk_pkg::cfg_type          cfg,
   input  logic [smsk_pkg::QCW-1:0]   q_count,
   output logic                       push,
   output smsk_pkg::task_type         push_task
);
   import smsk_pkg::*;

   localparam int WW   = $clog2(MAX_WIDTH + 1);
   localparam int CW   = $clog2(MAX_CHANNELS + 1);
   localparam int RLW  = $clog2(MAX_WIDTH * MAX_CHANNELS + 1);
   localparam int CMPW = (RLW > COL_W + 2) ? RLW + 1 : COL_W + 2;

   // line stores
   logic [7:0] centre_mem [STORE_DEPTH];
   logic [7:0] upper_mem  [STORE_DEPTH];

   // counters and window
   logic [COL_W-1:0] cc_ff, cc_in;
   logic [ROW_W-1:0] row_ff, row_in;
   logic [7:0]       window_ff [WIN_DEPTH];

   // first stage after accept
   logic                s1_valid_ff;
   logic                s1_emit_ff;
   logic                s1_border_ff;
   logic                s1_row_end_ff;
   logic                s1_frame_end_ff;
   logic [7:0]          s1_below_ff;
   logic [STORE_AW-1:0] s1_addr_ff;
   logic [7:0]          rd_c_ff, rd_u_ff, rd_r_ff;

   logic            accept;
   logic [WW-1:0]   w_cl;
   logic [11:0]     h_cl;
   logic [CW-1:0]   ch_cl;
   logic [RLW-1:0]  rowlen;
   logic [COL_W:0]  cc_plus;
   logic [ROW_W:0]  row_plus;
   logic            last_in_row;
   logic            row_wrap;
   logic            border;
   logic [STORE_AW-1:0] right_addr;
   logic [WIN_IW-1:0]   win_idx;

   // clamp configuration into legal ranges
   always_comb begin
      priority if (cfg.width_pixels < 12'd3) begin
         w_cl = WW'(3);
      end else if (32'(cfg.width_pixels) > MAX_WIDTH) begin
         w_cl = WW'(MAX_WIDTH);
      end else begin
         w_cl = WW'(cfg.width_pixels);
      end
      priority if (cfg.height_rows < HEIGHT_MIN) begin
         h_cl = HEIGHT_MIN;
      end else if (cfg.height_rows > HEIGHT_MAX) begin
         h_cl = HEIGHT_MAX;
      end else begin
         h_cl = cfg.height_rows;
      end
      priority if (cfg.channel_count == 3'd0) begin
         ch_cl = CW'(1);
      end else if (32'(cfg.channel_count) > MAX_CHANNELS) begin
         ch_cl = CW'(MAX_CHANNELS);
      end else begin
         ch_cl = CW'(cfg.channel_count);
      end
   end

   assign rowlen = RLW'(w_cl) * RLW'(ch_cl);

   // position classification
   assign cc_plus     = {1'b0, cc_ff} + (COL_W + 1)'(1);
   assign row_plus    = {1'b0, row_ff} + (ROW_W + 1)'(1);
   assign last_in_row = CMPW'(cc_plus) >= CMPW'(rowlen);
   assign row_wrap    = row_plus >= h_cl;
   assign border      = (row_ff == ROW_W'(1))
                      || (CMPW'(cc_ff) < CMPW'(ch_cl))
                      || ((CMPW'(cc_ff) + CMPW'(ch_cl)) >= CMPW'(rowlen));
   assign right_addr  = cc_ff + STORE_AW'(ch_cl);
   assign win_idx     = WIN_IW'(ch_cl - CW'(1));

   // room for this transaction and the one in the first stage
   assign req_stall = (q_count + QCW'(s1_valid_ff)) >= QCW'(QDEPTH);
   assign accept    = req_valid & ~req_stall;

   // counter next values
   always_comb begin
      cc_in  = cc_ff;
      row_in = row_ff;
      if (last_in_row) begin
         cc_in  = '0;
         row_in = row_wrap ? '0 : row_plus[ROW_W-1:0];
      end else begin
         cc_in  = cc_plus[COL_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cc_ff       <= '0;
         row_ff      <= '0;
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= accept;
         if (accept) begin
            cc_ff  <= cc_in;
            row_ff <= row_in;
         end
      end
   end

   // first stage payload
   always_ff @(posedge clock) begin
      if (accept) begin
         s1_emit_ff      <= row_ff != '0;
         s1_border_ff    <= border;
         s1_row_end_ff   <= last_in_row;
         s1_frame_end_ff <= last_in_row & row_wrap;
         s1_below_ff     <= req_sample;
         s1_addr_ff      <= cc_ff;
      end
   end

   // centre store: two reads and the new sample written at accept
   always_ff @(posedge clock) begin
      if (accept) begin
         rd_c_ff            <= centre_mem[cc_ff];
         rd_r_ff            <= centre_mem[right_addr];
         centre_mem[cc_ff]  <= req_sample;
      end
   end

   // upper store: read at accept, old centre written in the cycle after accept
   always_ff @(posedge clock) begin
      if (accept) begin
         rd_u_ff <= upper_mem[cc_ff];
      end
      if (s1_valid_ff) begin
         upper_mem[s1_addr_ff] <= rd_c_ff;
      end
   end

   // window of old centre samples, one shift per transaction
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < WIN_DEPTH; i++) begin
            window_ff[i] <= '0;
         end
      end else if (s1_valid_ff) begin
         window_ff[0] <= rd_c_ff;
         for (int i = 1; i < WIN_DEPTH; i++) begin
            window_ff[i] <= window_ff[i-1];
         end
      end
   end

   // task towards the queue
   assign push                = s1_valid_ff & s1_emit_ff;
   assign push_task.centre    = rd_c_ff;
   assign push_task.upper     = rd_u_ff;
   assign push_task.right     = rd_r_ff;
   assign push_task.left      = window_ff[win_idx];
   assign push_task.below     = s1_below_ff;
   assign push_task.border    = s1_border_ff;
   assign push_task.row_end   = s1_row_end_ff;
   assign push_task.frame_end = s1_frame_end_ff;

endmodule

// ===== design/smsk_queue.sv =====
// ---------------------------------------------------------------------------
// smsk_queue - short task queue between front and back end
// Four-entry FIFO; the head entry is visible while the queue is not empty.
// ---------------------------------------------------------------------------
module smsk_queue (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     push,
   input  smsk_pkg::task_type       push_task,
   input  logic                     pop,
   output logic                     not_empty,
   output smsk_pkg::task_type       head_task,
   output logic [smsk_pkg::QCW-1:0] count
);
   import smsk_pkg::*;

   task_type         entry_ff [QDEPTH];
   logic [QAW-1:0]   wr_ptr_ff, rd_ptr_ff;
   logic [QCW-1:0]   count_ff;

   assign not_empty = count_ff != '0;
   assign head_task = entry_ff[rd_ptr_ff];
   assign count     = count_ff;

   // pointers and fill level
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + QAW'(1);
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + QAW'(1);
         end
         unique case ({push, pop})
            2'b10:   count_ff <= count_ff + QCW'(1);
            2'b01:   count_ff <= count_ff - QCW'(1);
            default: count_ff <= count_ff;
         endcase
      end
   end

   // storage
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_task;
      end
   end

endmodule

// ===== design/smsk_back.sv =====
// ---------------------------------------------------------------------------
// smsk_back - mask arithmetic and result register
// Takes tasks from the queue, forms 5*centre minus the four neighbours,
// saturates to 0..255 and holds the result until the receiver takes it.
// ---------------------------------------------------------------------------
module smsk_back (
   input  logic               clock,
   input  logic               reset,
   input  logic               q_not_empty,
   input  smsk_pkg::task_type head_task,
   output logic               pop,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [7:0]         rsp_sharpened,
   output logic               rsp_row_end,
   output logic               rsp_frame_end
);
   import smsk_pkg::*;

   logic              rsp_valid_ff;
   logic [7:0]        sharpened_ff, sharpened_in;
   logic              row_end_ff, frame_end_ff;
   logic [10:0]       gain;
   logic [9:0]        nsum;
   logic signed [11:0] acc;

   // the output register is free or being emptied
   assign pop = q_not_empty & (~rsp_valid_ff | ~rsp_stall);

   // 5*centre - (left + right + upper + below), saturated
   always_comb begin
      gain = {1'b0, head_task.centre, 2'b00} + 11'(head_task.centre);
      nsum = 10'(head_task.left) + 10'(head_task.right)
           + 10'(head_task.upper) + 10'(head_task.below);
      acc  = signed'({1'b0, gain}) - signed'({2'b00, nsum});
      priority if (head_task.border) begin
         sharpened_in = 8'd0;
      end else if (acc < 0) begin
         sharpened_in = 8'd0;
      end else if (acc > 12'sd255) begin
         sharpened_in = 8'd255;
      end else begin
         sharpened_in = acc[7:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (pop) begin
         rsp_valid_ff <= 1'b1;
      end else if (~rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         sharpened_ff <= sharpened_in;
         row_end_ff   <= head_task.row_end;
         frame_end_ff <= head_task.frame_end;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_sharpened = sharpened_ff;
   assign rsp_row_end   = row_end_ff;
   assign rsp_frame_end = frame_end_ff;

endmodule

// ===== design/sharpen_mask_3x3_stream_core.sv =====
// ---------------------------------------------------------------------------
// sharpen_mask_3x3_stream_core - streaming 3x3 sharpening mask
// Raster-order 8-bit samples with interleaved channels go in on the req_
// channel; each result is 5*centre minus its four same-channel neighbours,
// saturated to 0..255, and leaves on the rsp_ channel.
//
// A result for row r is produced when the sample below it (row r+1) is
// accepted, so the first input row gives no results and rows 0..height-2
// are emitted; the all-zero last row is left to the consumer. Border
// positions give 0 but still flag row_end and frame_end.
// Throughput is one sample per clock while req_stall is low. From the
// accepting edge a sample passes the registered line store read, the
// task queue entry and the mask arithmetic into the result register.
// A four-entry task queue separates intake from arithmetic; while the
// receiver stalls, intake continues until that queue is full.
// Reset clears counters, window and queue and loads the default geometry
// (640 x 480, 3 channels); the line stores are not cleared, the first row of a
// frame fills them. Write configuration over csr_ only while idle, unenforced.
// ---------------------------------------------------------------------------
module sharpen_mask_3x3_stream_core #(
   parameter int MAX_WIDTH    = 2048,
   parameter int MAX_CHANNELS = 4
) (
   input  logic        clock,
   input  logic        reset,
   // sample input
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_sample,
   // result output
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_sharpened,
   output logic        rsp_row_end,
   output logic        rsp_frame_end,
   // register port
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [3:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);
   import smsk_pkg::*;

   cfg_type          cfg_ff;
   logic             csr_wr;
   logic [1:0]       csr_idx;

   logic             push;
   task_type         push_task;
   logic             pop;
   logic             q_not_empty;
   task_type         head_task;
   logic [QCW-1:0]   q_count;

   // register port
   assign csr_pready = 1'b1;
   assign csr_idx    = csr_paddr[3:2];
   assign csr_wr     = csr_psel & csr_penable & csr_pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.width_pixels  <= WIDTH_RESET;
         cfg_ff.height_rows   <= HEIGHT_RESET;
         cfg_ff.channel_count <= CHANNEL_RESET;
      end else if (csr_wr) begin
         unique case (csr_idx)
            REG_WIDTH_PIXELS:  cfg_ff.width_pixels  <= csr_pwdata[11:0];
            REG_HEIGHT_ROWS:   cfg_ff.height_rows   <= csr_pwdata[11:0];
            REG_CHANNEL_COUNT: cfg_ff.channel_count <= csr_pwdata[2:0];
            default:           cfg_ff <= cfg_ff;
         endcase
      end
   end

   // register read back
   always_comb begin
      unique case (csr_idx)
         REG_WIDTH_PIXELS:  csr_prdata = 32'(cfg_ff.width_pixels);
         REG_HEIGHT_ROWS:   csr_prdata = 32'(cfg_ff.height_rows);
         REG_CHANNEL_COUNT: csr_prdata = 32'(cfg_ff.channel_count);
         default:           csr_prdata = '0;
      endcase
   end

   // intake and classification
   smsk_front #(
      .MAX_WIDTH    (MAX_WIDTH),
      .MAX_CHANNELS (MAX_CHANNELS)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_sample (req_sample),
      .cfg        (cfg_ff),
      .q_count    (q_count),
      .push       (push),
      .push_task  (push_task)
   );

   // task queue
   smsk_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_task (push_task),
      .pop       (pop),
      .not_empty (q_not_empty),
      .head_task (head_task),
      .count     (q_count)
   );

   // arithmetic and result register
   smsk_back u_back (
      .clock         (clock),
      .reset         (reset),
      .q_not_empty   (q_not_empty),
      .head_task     (head_task),
      .pop           (pop),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_sharpened (rsp_sharpened),
      .rsp_row_end   (rsp_row_end),
      .rsp_frame_end (rsp_frame_end)
   );

endmodule
